### sv/cef_pkg.sv
// ----------------------------------------------------------------------------
// cef_pkg: shared types and constants
// Request and result layouts, cell control group and register indexes for
// the filtered colex combination enumerator.
// ----------------------------------------------------------------------------
package cef_pkg;

	localparam int ELEM_W = 6;
	localparam int SLOT_W = 4;
	localparam int MASK_W = 64;
	localparam int N_W    = 7;
	localparam int K_W    = 5;
	localparam int IDX_W  = 7;
	localparam int CFG_W  = 64;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_SUBSET_DEF = 16;
	localparam int MAX_SET_DEF    = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_MASK = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [SLOT_W-1:0] element_slot;
		logic [ELEM_W-1:0] element_value;
	} request_t;

	typedef struct packed {
		logic              found;
		logic [MASK_W-1:0] subset_mask;
	} result_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_CAPTURE,
		CELL_ADV_A,
		CELL_ADV_B,
		CELL_WRAP
	} cell_cmd_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		cell_cmd_t         cmd;
		logic [SLOT_W-1:0] slot;
		logic [ELEM_W-1:0] value;
		logic [ELEM_W-1:0] pos;
		logic [ELEM_W-1:0] lo;
		logic [K_W-1:0]    r;
		logic [K_W-1:0]    k;
		logic [N_W-1:0]    n;
	} cell_ctrl_t;

	typedef struct packed {
		logic eq;
		logic above_inc;
		logic order_ok;
	} cell_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_WRAP,
		ST_EMIT
	} state_t;

endpackage

### sv/cef_cell.sv
// ----------------------------------------------------------------------------
// cef_cell: one subset slot
// Holds one element, compares it with the scan position, checks order
// against its lower neighbour and rewrites itself on a write, an advance or a wrap.
// ----------------------------------------------------------------------------
module cef_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cef_pkg::cell_ctrl_t         ctrl,
	input  logic [cef_pkg::MASK_W-1:0]  include_mask,
	input  logic [cef_pkg::ELEM_W-1:0]  prev_elem,
	output logic [cef_pkg::ELEM_W-1:0]  elem,
	output cef_pkg::cell_stat_t         stat
);
	import cef_pkg::*;

	localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);
	localparam bit FIRST = (IDX == 0);

	logic [ELEM_W-1:0] elem_q;
	logic              inc_q;
	logic              active;
	logic              order_in;
	logic [IDX_W-1:0]  r_ext;
	logic [IDX_W-1:0]  idx_p1;

	assign active = IDX_V < IDX_W'(ctrl.k);
	assign r_ext  = IDX_W'(ctrl.r);
	assign idx_p1 = IDX_V + IDX_W'(1);
	assign order_in = FIRST ? 1'b1 : (prev_elem < elem_q);

	always_comb begin
		stat.eq        = active && (elem_q == ctrl.pos);
		stat.above_inc = active && inc_q && (elem_q > ctrl.pos);
		stat.order_ok  = !active || ((N_W'(elem_q) < ctrl.n) && order_in);
	end

	assign elem = elem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= ELEM_W'(IDX);
		end else begin
			unique case (ctrl.cmd)
				CELL_WRITE: begin
					if (IDX_V == IDX_W'(ctrl.slot))
						elem_q <= ctrl.value;
				end
				CELL_ADV_A: begin
					if (IDX_V < r_ext)
						elem_q <= ELEM_W'(IDX);
					else if (IDX_V == r_ext)
						elem_q <= ctrl.pos;
				end
				CELL_ADV_B: begin
					if (idx_p1 < r_ext)
						elem_q <= ELEM_W'(IDX);
					else if (idx_p1 == r_ext)
						elem_q <= ctrl.lo;
					else if (IDX_V == r_ext)
						elem_q <= ctrl.pos;
				end
				CELL_WRAP: begin
					if (active)
						elem_q <= ELEM_W'(IDX);
				end
				default: begin
				end
			endcase
		end
	end

	// filter bit of the held element, sampled once before the scan
	always_ff @(posedge clk) begin
		if (ctrl.cmd == CELL_CAPTURE)
			inc_q <= include_mask[elem_q];
	end

endmodule

### sv/combination_enumerator_filtered.sv
// ----------------------------------------------------------------------------
// combination_enumerator_filtered: filtered colex k-combination successor
// A write request loads one slot; a step request scans bit positions upward
// to find the next combination that meets the include mask.
// ----------------------------------------------------------------------------
// Write: taken while idle, no result, busy stays low.
// Step: busy through setup, a scan of base-set positions upward (one scan cycle
//   per position, up to n), wrap and emit; a hit ends the scan and skips wrap. done
//   is registered from emit, and the next request is taken in the done cycle.
// Done is high for one cycle with the result; the receiver cannot stall.
// Reset: slot i holds i, n = 64, k = 1, include mask empty, block idle.
module combination_enumerator_filtered #(
	parameter int MAX_SUBSET = cef_pkg::MAX_SUBSET_DEF,
	parameter int MAX_SET    = cef_pkg::MAX_SET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cef_pkg::request_t             request,
	output logic                          done,
	output cef_pkg::result_t              result,
	input  logic                          cfg_wr_en,
	input  logic [cef_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cef_pkg::CFG_W-1:0]     cfg_wdata
);
	import cef_pkg::*;

	state_t state_q, state_d;

	logic [N_W-1:0]    set_size_q;
	logic [K_W-1:0]    subset_size_q;
	logic [MASK_W-1:0] include_mask_q;

	logic [ELEM_W-1:0] pos_q;
	logic [K_W-1:0]    cnt_q;
	logic              mseen_q;
	logic [ELEM_W-1:0] mlo_q;
	logic              found_q;
	logic              done_q;
	result_t           result_q;

	logic [N_W-1:0]    n_eff;
	logic [K_W-1:0]    k_eff;
	logic [K_W-1:0]    r;
	logic              eq_any, above_any, all_ok;
	logic              cand, hit_a, hit_b, last;
	logic [MASK_W-1:0] cur_mask;
	cell_ctrl_t        ctrl;

	logic [ELEM_W-1:0] elem [MAX_SUBSET];
	cell_stat_t        stat [MAX_SUBSET];
	logic [MAX_SUBSET-1:0] eq_vec, above_vec, ok_vec;

	assign n_eff = (set_size_q > N_W'(MAX_SET)) ? N_W'(MAX_SET) : set_size_q;
	assign k_eff = (IDX_W'(subset_size_q) > IDX_W'(MAX_SUBSET)) ?
	               K_W'(MAX_SUBSET) : subset_size_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q     <= N_W'(64);
			subset_size_q  <= K_W'(1);
			include_mask_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_SET_SIZE:     set_size_q     <= cfg_wdata[N_W-1:0];
				REG_SUBSET_SIZE:  subset_size_q  <= cfg_wdata[K_W-1:0];
				REG_INCLUDE_MASK: include_mask_q <= cfg_wdata[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// row of slot cells, each checking order against the one below
	for (genvar i = 0; i < MAX_SUBSET; i++) begin : g_cell
		cef_cell #(.IDX(i)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.include_mask (include_mask_q),
			.prev_elem    ((i == 0) ? '0 : elem[(i == 0) ? 0 : i - 1]),
			.elem         (elem[i]),
			.stat         (stat[i])
		);
		assign eq_vec[i]    = stat[i].eq;
		assign above_vec[i] = stat[i].above_inc;
		assign ok_vec[i]    = stat[i].order_ok;
	end

	assign eq_any    = |eq_vec;
	assign above_any = |above_vec;
	assign all_ok    = (&ok_vec) && (N_W'(k_eff) <= n_eff);

	// position p is free and the count below it leaves r low elements
	assign r     = cnt_q - K_W'(1);
	assign cand  = !eq_any && (cnt_q != '0);
	assign hit_a = cand && (include_mask_q[pos_q] || above_any ||
	               (mseen_q && (mlo_q < ELEM_W'(r))));
	assign hit_b = cand && !hit_a && (r != '0) && mseen_q;
	assign last  = (N_W'(pos_q) + N_W'(1)) == n_eff;

	always_comb begin
		cur_mask = '0;
		for (int i = 0; i < MAX_SUBSET; i++) begin
			if (IDX_W'(i) < IDX_W'(k_eff))
				cur_mask[elem[i]] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		ctrl.cmd   = CELL_HOLD;
		ctrl.slot  = request.element_slot;
		ctrl.value = request.element_value;
		ctrl.pos   = pos_q;
		ctrl.lo    = mlo_q;
		ctrl.r     = r;
		ctrl.k     = k_eff;
		ctrl.n     = n_eff;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (request.opcode == OP_WRITE)
						ctrl.cmd = CELL_WRITE;
					else
						state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctrl.cmd = CELL_CAPTURE;
				state_d  = (all_ok && n_eff != '0) ? ST_SCAN : ST_WRAP;
			end
			ST_SCAN: begin
				if (hit_a) begin
					ctrl.cmd = CELL_ADV_A;
					state_d  = ST_EMIT;
				end else if (hit_b) begin
					ctrl.cmd = CELL_ADV_B;
					state_d  = ST_EMIT;
				end else if (last) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				ctrl.cmd = CELL_WRAP;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan position, count of elements below it, lowest filter bit so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			cnt_q   <= '0;
			mseen_q <= 1'b0;
			mlo_q   <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SETUP: begin
					pos_q   <= '0;
					cnt_q   <= '0;
					mseen_q <= 1'b0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (hit_a || hit_b) begin
						found_q <= 1'b1;
					end else begin
						pos_q <= pos_q + ELEM_W'(1);
						cnt_q <= cnt_q + K_W'(eq_any);
						if (include_mask_q[pos_q] && !mseen_q) begin
							mseen_q <= 1'b1;
							mlo_q   <= pos_q;
						end
					end
				end
				ST_WRAP: found_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == ST_EMIT);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			result_q.found       <= found_q;
			result_q.subset_mask <= cur_mask;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### sv/cef_checker.sv
// ----------------------------------------------------------------------------
// cef_checker: port-level checks
// Watches the request, result and busy ports of the enumerator over time.
// ----------------------------------------------------------------------------
module cef_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input cef_pkg::request_t             request,
	input logic                          done,
	input cef_pkg::result_t              result,
	input logic                          cfg_wr_en,
	input logic [cef_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [cef_pkg::CFG_W-1:0]     cfg_wdata
);
	import cef_pkg::*;

	// a step request keeps the block busy in the next cycle
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.opcode == OP_STEP |=> busy)
		else $error("step request did not raise busy");

	// a write request produces no result and no busy period
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.opcode == OP_WRITE |=> !busy && !done)
		else $error("write request disturbed busy or done");

	// each result closes exactly one busy period
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("result without end of busy period");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy period ended without a result");

	// a found combination is never empty
	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |-> result.subset_mask != '0)
		else $error("found with an empty subset");

endmodule

bind combination_enumerator_filtered cef_checker u_cef_checker (.*);

### verif/tb_combination_enumerator_filtered.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_combination_enumerator_filtered: self-checking bench for the enumerator
// Drives element writes and step requests with random gaps. A predictor that
// mirrors the element list and registers works out the result of every
// step, and each result is checked against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tb_combination_enumerator_filtered;
	import cef_pkg::*;

	localparam int STEP_LATENCY   = MAX_SET_DEF + 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_TARGET   = 1900;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	request_t             request;
	logic                 done;
	result_t              result;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	combination_enumerator_filtered u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [ELEM_W-1:0] elems [MAX_SUBSET_DEF];
	logic [N_W-1:0]    cfg_n;
	logic [K_W-1:0]    cfg_k;
	logic [MASK_W-1:0] cfg_mask;

	result_t pending_subsets [$];
	result_t want;

	int  errors;
	int  n_items;
	int  n_writes;
	int  n_steps;
	int  n_found;
	int  n_wrapped;
	int  n_settings;
	int  idle_cycles;
	bit  gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_set_size();
		return (cfg_n > MAX_SET_DEF) ? MAX_SET_DEF : int'(cfg_n);
	endfunction

	function automatic int eff_subset_size();
		return (cfg_k > MAX_SUBSET_DEF) ? MAX_SUBSET_DEF : int'(cfg_k);
	endfunction

	function automatic logic [MASK_W-1:0] held_subset(input int k);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < k; i++)
			m |= 64'd1 << elems[i];
		return m;
	endfunction

	function automatic bit ordered_subset(input int k, input int n);
		if (k > n)
			return 1'b0;
		for (int i = 0; i < k; i++) begin
			if (elems[i] >= n)
				return 1'b0;
			if (i > 0 && elems[i-1] >= elems[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Colex order of k-subsets is numeric order of their masks: try each
	// free position p as the lowest changed high bit, refill the rest low.
	function automatic bit next_filtered_combination(input logic [MASK_W-1:0] cur,
			input int k, input int n, input logic [MASK_W-1:0] filt,
			output logic [MASK_W-1:0] nxt);
		logic [MASK_W-1:0] upper;
		logic [MASK_W-1:0] lower_filt;
		logic [MASK_W-1:0] cand;
		int ones;
		int rest;
		int lo;
		nxt = '0;
		for (int p = 0; p < n; p++) begin
			if (cur[p])
				continue;
			upper = (p < 63) ? ((cur >> (p + 1)) << (p + 1)) : 64'd0;
			upper[p] = 1'b1;
			ones = $countones(upper);
			if (ones > k)
				continue;
			rest = k - ones;
			if (rest > p)
				continue;
			cand = upper | ((64'd1 << rest) - 64'd1);
			if ((cand & filt) != 0) begin
				nxt = cand;
				return 1'b1;
			end
			if (rest == 0)
				continue;
			lower_filt = filt & ((64'd1 << p) - 64'd1);
			if (lower_filt == 0)
				continue;
			lo = 0;
			while (!lower_filt[lo])
				lo++;
			nxt = upper | ((64'd1 << (rest - 1)) - 64'd1) | (64'd1 << lo);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t predict_step();
		int k;
		int n;
		int slot;
		bit hit;
		logic [MASK_W-1:0] nxt;
		result_t r;
		k = eff_subset_size();
		n = eff_set_size();
		hit = 1'b0;
		nxt = '0;
		if (ordered_subset(k, n))
			hit = next_filtered_combination(held_subset(k), k, n, cfg_mask, nxt);
		if (hit) begin
			slot = 0;
			for (int b = 0; b < MASK_W && slot < k; b++)
				if (nxt[b]) begin
					elems[slot] = ELEM_W'(b);
					slot++;
				end
		end else begin
			for (int i = 0; i < k; i++)
				elems[i] = ELEM_W'(i);
		end
		r.found = hit;
		r.subset_mask = held_subset(k);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with start still high, so the caller must send again or settle at once
	task automatic send_request(input request_t rq);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		request <= rq;
		do
			@(posedge clk);
		while (busy);
		if (rq.opcode == OP_STEP) begin
			pending_subsets.push_back(predict_step());
			n_steps++;
		end else begin
			elems[rq.element_slot] = rq.element_value;
			n_writes++;
		end
		n_items++;
		@(negedge clk);
	endtask

	task automatic put_element(input int slot, input int value);
		request_t rq;
		rq.opcode        = OP_WRITE;
		rq.element_slot  = SLOT_W'(slot);
		rq.element_value = ELEM_W'(value);
		send_request(rq);
	endtask

	task automatic step_once();
		request_t rq;
		rq = '0;
		rq.opcode = OP_STEP;
		send_request(rq);
	endtask

	// hold off until every result is in, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		wait (pending_subsets.size() == 0);
		repeat (STEP_LATENCY) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		case (idx)
			REG_SET_SIZE:     cfg_n    = data[N_W-1:0];
			REG_SUBSET_SIZE:  cfg_k    = data[K_W-1:0];
			REG_INCLUDE_MASK: cfg_mask = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [N_W-1:0] n_val, input logic [K_W-1:0] k_val,
			input logic [MASK_W-1:0] mask_val);
		settle();
		put_reg(REG_SET_SIZE, CFG_W'(n_val));
		put_reg(REG_SUBSET_SIZE, CFG_W'(k_val));
		put_reg(REG_INCLUDE_MASK, mask_val);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [MASK_W-1:0] random_subset(input int n, input int k);
		logic [MASK_W-1:0] bits;
		bits = '0;
		while ($countones(bits) < k)
			bits[$urandom_range(0, n - 1)] = 1'b1;
		return bits;
	endfunction

	task automatic load_subset(input logic [MASK_W-1:0] bits);
		int slot;
		slot = 0;
		for (int b = 0; b < MASK_W; b++)
			if (bits[b]) begin
				put_element(slot, b);
				slot++;
			end
	endtask

	function automatic logic [MASK_W-1:0] pick_filter(input int n);
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			4: return {$urandom, $urandom};
			5: return (n > 0) ? (64'd1 << $urandom_range(0, n - 1)) : 64'd0;
			default: return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
		endcase
	endfunction

	task automatic test_reset_state();
		gaps_on = 1'b0;
		// empty include mask out of reset: wraps to the first element
		step_once();
	endtask

	task automatic test_special_cases();
		gaps_on = 1'b1;
		set_config(7'd64, 5'd2, 64'd1 << 63);
		put_element(0, 0);
		put_element(1, 63);
		step_once();
		// slot beyond k is kept but ignored; last combination wraps
		put_element(15, 63);
		put_element(0, 62);
		step_once();
		// equal neighbours
		put_element(0, 5);
		put_element(1, 5);
		step_once();
		// element outside the base set
		set_config(7'd8, 5'd2, '1);
		put_element(1, 9);
		step_once();
		// empty subset, then subset larger than the base set
		set_config(7'd8, 5'd0, '1);
		step_once();
		set_config(7'd8, 5'd9, '1);
		step_once();
		// oversized registers clamp; empty mask
		set_config(7'd127, 5'd31, '0);
		step_once();
		// mask bit that no later combination can hold
		set_config(7'd64, 5'd2, 64'd1);
		put_element(0, 1);
		put_element(1, 63);
		step_once();
		set_config(7'd127, 5'd31, '1);
		step_once();
		step_once();
	endtask

	// walk a small base set past its last combination
	task automatic test_full_enumeration();
		int n;
		int k;
		for (int pass = 0; pass < 2; pass++) begin
			n = $urandom_range(3, 7);
			k = $urandom_range(1, n);
			set_config(N_W'(n), K_W'(k), '1);
			gaps_on = (pass == 1);
			for (int i = 0; i < k; i++)
				put_element(i, i);
			repeat (40) step_once();
		end
	endtask

	task automatic test_random_walks();
		int n;
		int k;
		int n_eff;
		int k_eff;
		int steps;
		bit first;
		first = 1'b1;
		while (n_items < ITEMS_TARGET) begin
			if (first || $urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 4))
						0: n = 0;
						1: n = 1;
						2: n = 64;
						3: n = 65;
						default: n = 127;
					endcase
				end else if ($urandom_range(0, 1) == 0)
					n = $urandom_range(1, 12);
				else
					n = $urandom_range(1, 64);
				n_eff = (n > MAX_SET_DEF) ? MAX_SET_DEF : n;
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: k = 0;
						1: k = 16;
						2: k = 17;
						default: k = 31;
					endcase
				end else
					k = $urandom_range(1, (n_eff < 1) ? 1 : ((n_eff < 16) ? n_eff : 16));
				set_config(N_W'(n), K_W'(k), pick_filter(n_eff));
				first = 1'b0;
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			n_eff = eff_set_size();
			k_eff = eff_subset_size();
			if (k_eff > 0 && k_eff <= n_eff && $urandom_range(0, 9) != 0)
				load_subset(random_subset(n_eff, k_eff));
			steps = $urandom_range(1, 12);
			repeat (steps) begin
				if ($urandom_range(0, 9) == 0)
					put_element($urandom_range(0, 15), $urandom_range(0, 63));
				else
					step_once();
			end
			if ($urandom_range(0, 7) == 0)
				settle();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_subsets.size() == 0) begin
				$display("%0t: unexpected result found=%0b mask=%h", $time,
					result.found, result.subset_mask);
				errors++;
			end else begin
				want = pending_subsets.pop_front();
				if (result.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						want.found, result.found);
					errors++;
				end
				if (result.subset_mask !== want.subset_mask) begin
					$display("%0t: subset_mask expected %h actual %h", $time,
						want.subset_mask, result.subset_mask);
					errors++;
				end
			end
			if (result.found)
				n_found++;
			else
				n_wrapped++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_wr_en)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
				idle_cycles, pending_subsets.size());
			$display("tb_combination_enumerator_filtered NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_wr_en = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		cfg_n     = N_W'(64);
		cfg_k     = K_W'(1);
		cfg_mask  = '0;
		for (int i = 0; i < MAX_SUBSET_DEF; i++)
			elems[i] = ELEM_W'(i);
		errors = 0;
		n_items = 0;
		n_writes = 0;
		n_steps = 0;
		n_found = 0;
		n_wrapped = 0;
		n_settings = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_special_cases();
		test_full_enumeration();
		test_random_walks();
		settle();

		$display("Covered %0d element writes and %0d steps over %0d register settings;",
			n_writes, n_steps, n_settings);
		$display("  %0d steps reached a filtered combination, %0d wrapped.",
			n_found, n_wrapped);
		if (errors == 0)
			$display("tb_combination_enumerator_filtered OK");
		else
			$display("tb_combination_enumerator_filtered NOT OK");
		$finish;
	end

endmodule
